// ----- rtl/lte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lockset table package
// Operation and status codes, the command record that the front hands to
// the back, and the fixed widths of the item fields.
// ----------------------------------------------------------------------------
package lte_pkg;

	// Fixed widths of the item fields.
	localparam int LOCK_ID_W = 16;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 5;

	// Depth of the command queue between front and back.
	localparam int CMD_Q_DEPTH = 2;
	localparam int CMD_Q_AW    = 1;

	// Operation codes on the input side.
	localparam logic [OP_W-1:0] OP_ADD_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE    = 2'd2;
	localparam logic [OP_W-1:0] OP_PROBE     = 2'd3;

	// Status codes on the result side.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	// Classified command kinds.
	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_REMOVE,
		CMD_PROBE
	} cmd_kind_t;

	// One classified command.
	typedef struct packed {
		cmd_kind_t              kind;
		logic [LOCK_ID_W-1:0]   id;
		logic                   is_write;
		logic                   clear;
	} cmd_t;

endpackage

// ----- rtl/lte_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lockset table front end
// Accepts input items, classifies them into commands and holds them in a
// short queue until the back end takes them.
// ----------------------------------------------------------------------------
module lte_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [lte_pkg::OP_W-1:0]      operation,
	input  logic [lte_pkg::LOCK_ID_W-1:0] lock_id,
	input  logic                          probe_is_write,
	input  logic                          query_start,
	output lte_pkg::cmd_t                 cmd,
	output logic                          cmd_valid,
	input  logic                          cmd_pop
);
	import lte_pkg::*;

	cmd_t                 q_mem_q [CMD_Q_DEPTH];
	logic [CMD_Q_AW-1:0]  wr_ptr_q;
	logic [CMD_Q_AW-1:0]  rd_ptr_q;
	logic [CMD_Q_AW:0]    fill_q;
	cmd_t                 cmd_in;
	logic                 do_push;
	logic                 do_pop;

	// Classify the incoming item.
	always_comb begin
		cmd_in.id       = lock_id;
		cmd_in.is_write = 1'b0;
		cmd_in.clear    = 1'b0;
		cmd_in.kind     = CMD_PROBE;
		unique case (operation)
			OP_ADD_WRITE: begin
				cmd_in.kind     = CMD_ADD;
				cmd_in.is_write = 1'b1;
			end
			OP_ADD_READ: begin
				cmd_in.kind = CMD_ADD;
			end
			OP_REMOVE: begin
				cmd_in.kind = CMD_REMOVE;
			end
			OP_PROBE: begin
				cmd_in.kind     = CMD_PROBE;
				cmd_in.is_write = probe_is_write;
				cmd_in.clear    = query_start;
			end
		endcase
	end

	assign full      = (fill_q == (CMD_Q_AW+1)'(CMD_Q_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = q_mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!do_push && do_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/lte_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lockset table back end
// Executes commands against the lock table memory, one entry per cycle for
// searches, and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module lte_back #(
	parameter int MAX_LOCKS = 16,
	parameter int ID_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lte_pkg::cmd_t                cmd,
	input  logic                         cmd_valid,
	output logic                         cmd_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [lte_pkg::STATUS_W-1:0] status,
	output logic                         excluded,
	output logic [lte_pkg::COUNT_W-1:0]  held_count
);
	import lte_pkg::*;

	localparam int IW = (ID_BITS < LOCK_ID_W) ? ID_BITS : LOCK_ID_W;
	localparam int AW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
	localparam int CW = $clog2(MAX_LOCKS + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_MOVE   = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [IW-1:0]       mem_id [MAX_LOCKS];
	logic                mem_w  [MAX_LOCKS];
	logic [IW-1:0]       rd_id_q;
	logic                rd_w_q;

	logic [1:0]          state_q;
	cmd_t                cmd_q;
	logic [AW-1:0]       idx_q;
	logic [CW-1:0]       count_q;
	logic                excl_q;
	logic [STATUS_W-1:0] stat_q;

	logic                res_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                res_excl_q;
	logic [COUNT_W-1:0]  res_count_q;

	logic                we;
	logic [AW-1:0]       wr_addr;
	logic [IW-1:0]       wr_id;
	logic                wr_w;
	logic [AW-1:0]       rd_addr;
	logic [CW-1:0]       last_cnt;
	logic [AW-1:0]       last_idx;
	logic                is_last;
	logic                id_match;
	logic                slot_free;

	assign last_cnt  = count_q - CW'(1);
	assign last_idx  = last_cnt[AW-1:0];
	assign is_last   = (CW'(idx_q) == last_cnt);
	assign id_match  = (rd_id_q == cmd_q.id[IW-1:0]);
	assign slot_free = !res_valid_q || pop;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;

	// Memory port control: adds write at the tail, a remove writes the moved entry.
	always_comb begin
		we      = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_id   = cmd.id[IW-1:0];
		wr_w    = cmd.is_write;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				we = cmd_valid && (cmd.kind == CMD_ADD) &&
					(count_q != CW'(MAX_LOCKS));
			end
			S_SEARCH: begin
				if ((cmd_q.kind == CMD_REMOVE) && id_match) begin
					rd_addr = last_idx;
				end else begin
					rd_addr = idx_q + 1'b1;
				end
			end
			S_MOVE: begin
				we      = 1'b1;
				wr_addr = idx_q;
				wr_id   = rd_id_q;
				wr_w    = rd_w_q;
			end
			S_DONE: begin
				we = 1'b0;
			end
		endcase
	end

	// Lock table memory with registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_id[wr_addr] <= wr_id;
			mem_w[wr_addr]  <= wr_w;
		end
		rd_id_q <= mem_id[rd_addr];
		rd_w_q  <= mem_w[rd_addr];
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			excl_q  <= 1'b0;
			idx_q   <= '0;
			stat_q  <= ST_OK;
			cmd_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q  <= cmd;
						idx_q  <= '0;
						stat_q <= ST_OK;
						unique case (cmd.kind)
							CMD_ADD: begin
								if (count_q == CW'(MAX_LOCKS)) begin
									stat_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_DONE;
							end
							CMD_REMOVE: begin
								if (count_q == '0) begin
									stat_q  <= ST_NOT_FOUND;
									state_q <= S_DONE;
								end else begin
									state_q <= S_SEARCH;
								end
							end
							CMD_PROBE: begin
								if (cmd.clear) begin
									excl_q <= 1'b0;
								end
								state_q <= (count_q == '0) ? S_DONE : S_SEARCH;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SEARCH: begin
					// Read data holds the entry at idx_q.
					if (cmd_q.kind == CMD_REMOVE) begin
						if (id_match) begin
							state_q <= S_MOVE;
						end else if (is_last) begin
							stat_q  <= ST_NOT_FOUND;
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						if (id_match && (rd_w_q || cmd_q.is_write)) begin
							excl_q  <= 1'b1;
							state_q <= S_DONE;
						end else if (is_last) begin
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_MOVE: begin
					// The last entry has been written into the freed slot.
					count_q <= last_cnt;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Output register: holds one finished result until it is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && slot_free) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && slot_free) begin
			res_status_q <= stat_q;
			res_excl_q   <= excl_q;
			res_count_q  <= COUNT_W'(count_q);
		end
	end

	assign empty      = !res_valid_q;
	assign status     = res_status_q;
	assign excluded   = res_excl_q;
	assign held_count = res_count_q;

endmodule

// ----- rtl/lockset_table_exclusion_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lockset table exclusion unit
// Keeps a table of held locks and probes elements of other lock sets
// against it, raising a sticky excluded flag on a conflict.
// ----------------------------------------------------------------------------
// Usage:
// Items enter through a queue-like port: an item transfers when push is high
// and full is low. Each item yields exactly one result, offered on status,
// excluded and held_count while empty is low, and transferred when pop is
// high and empty is low. Results come out in item order.
// A front end classifies items into a two-entry command queue; the back end
// executes one command at a time against the table memory. An add goes from
// the idle state straight to the done state. A remove or probe scans the
// table one entry per cycle through the memory's registered read port, up to
// MAX_LOCKS entries; a remove that hits then moves the last entry into the
// freed slot. An item passes from the command queue through the back end's
// sequencer to the output register before its result appears.
// Reset empties the table and clears the excluded flag; table contents are
// not cleared, since only entries below the count are read. When the result
// side stalls, one finished result waits in the output register and the
// command queue keeps accepting items until it is full.
// ----------------------------------------------------------------------------
module lockset_table_exclusion_unit #(
	parameter int MAX_LOCKS = 16,
	parameter int ID_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [lte_pkg::OP_W-1:0]      operation,
	input  logic [lte_pkg::LOCK_ID_W-1:0] lock_id,
	input  logic                          probe_is_write,
	input  logic                          query_start,
	output logic                          empty,
	input  logic                          pop,
	output logic [lte_pkg::STATUS_W-1:0]  status,
	output logic                          excluded,
	output logic [lte_pkg::COUNT_W-1:0]   held_count
);
	import lte_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	// Item intake and classification.
	lte_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.operation      (operation),
		.lock_id        (lock_id),
		.probe_is_write (probe_is_write),
		.query_start    (query_start),
		.cmd            (cmd),
		.cmd_valid      (cmd_valid),
		.cmd_pop        (cmd_pop)
	);

	// Table execution and result delivery.
	lte_back #(
		.MAX_LOCKS (MAX_LOCKS),
		.ID_BITS   (ID_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.excluded   (excluded),
		.held_count (held_count)
	);

endmodule

// ----- bench/tb_lockset_table_exclusion_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lockset table exclusion unit testbench
// Drives add, remove and probe items into the unit and checks every result
// against a cycle-free model of the lock table that is kept in a scoreboard.
// A directed opening covers the empty and full table, duplicate ids and the
// sticky flag. Random sequences then move the table between empty and full.
// Both sides idle at random, and one long receiver hold-off fills the unit
// until it stalls its input.
// ----------------------------------------------------------------------------
module tb_lockset_table_exclusion_unit;

	import lte_pkg::*;

	localparam int MAX_LOCKS = 16;
	localparam int ID_BITS   = 16;
	localparam logic [LOCK_ID_W-1:0] ID_MASK =
		(ID_BITS >= LOCK_ID_W) ? {LOCK_ID_W{1'b1}} : LOCK_ID_W'((1 << ID_BITS) - 1);
	localparam int RANDOM_ITEMS = 950;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 25;

	// One result as seen on the output ports.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                excluded;
		logic [COUNT_W-1:0]  held_count;
	} lock_result_t;

	// Model of the lock table and the queue of results it predicts.
	class lock_scoreboard;
		logic [LOCK_ID_W-1:0] held_id[MAX_LOCKS];
		bit                   held_write[MAX_LOCKS];
		int unsigned          held;
		bit                   excl_flag;
		lock_result_t         expected_q[$];
		int                   mismatches;
		int                   results_seen;

		function new();
			held = 0;
			excl_flag = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		// Apply one accepted item to the table and queue its result.
		function void note_item(logic [OP_W-1:0] op, logic [LOCK_ID_W-1:0] id_in,
			bit probe_write, bit start);
			logic [LOCK_ID_W-1:0] id;
			lock_result_t r;
			bit found;
			id = id_in & ID_MASK;
			r.status = ST_OK;
			found = 0;
			case (op)
				OP_ADD_WRITE, OP_ADD_READ: begin
					if (held >= MAX_LOCKS) begin
						r.status = ST_FULL;
					end else begin
						held_id[held] = id;
						held_write[held] = (op == OP_ADD_WRITE);
						held++;
					end
				end
				OP_REMOVE: begin
					// The first matching slot goes; the last entry fills it.
					for (int i = 0; i < held && !found; i++) begin
						if (held_id[i] == id) begin
							held_id[i] = held_id[held - 1];
							held_write[i] = held_write[held - 1];
							held--;
							found = 1;
						end
					end
					if (!found)
						r.status = ST_NOT_FOUND;
				end
				default: begin
					if (start)
						excl_flag = 0;
					for (int i = 0; i < held; i++) begin
						if (held_id[i] == id && (held_write[i] || probe_write))
							excl_flag = 1;
					end
				end
			endcase
			r.excluded = excl_flag;
			r.held_count = COUNT_W'(held);
			expected_q = {expected_q, r};
		endfunction

		// Compare one transferred result with the oldest prediction.
		function void check_result(lock_result_t got);
			lock_result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing predicted: status %0d excl %0d count %0d",
						results_seen, got.status, got.excluded, got.held_count);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.excluded !== want.excluded ||
				got.held_count !== want.held_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d mismatch: status %0d/%0d excl %0d/%0d count %0d/%0d (exp/got)",
						results_seen, want.status, got.status, want.excluded, got.excluded,
						want.held_count, got.held_count);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [OP_W-1:0]      operation;
	logic [LOCK_ID_W-1:0] lock_id;
	logic                 probe_is_write;
	logic                 query_start;
	logic                 empty;
	logic                 pop;
	logic [STATUS_W-1:0]  status;
	logic                 excluded;
	logic [COUNT_W-1:0]   held_count;

	lock_scoreboard sb;
	bit             steady_run;

	lockset_table_exclusion_unit #(
		.MAX_LOCKS(MAX_LOCKS),
		.ID_BITS  (ID_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.lock_id       (lock_id),
		.probe_is_write(probe_is_write),
		.query_start   (query_start),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.excluded      (excluded),
		.held_count    (held_count)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both handshakes on the edge, before any drive from this edge lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_item(operation, lock_id, probe_is_write, query_start);
			if (pop && !empty)
				sb.check_result('{status, excluded, held_count});
		end
	end

	// Offer one item and hold it until the transfer, then maybe idle a while.
	task automatic offer_item(input logic [OP_W-1:0] op, input logic [LOCK_ID_W-1:0] id,
		input bit probe_write, input bit start);
		push <= 1'b1;
		operation <= op;
		lock_id <= id;
		probe_is_write <= probe_write;
		query_start <= start;
		do @(posedge clk); while (full);
		if (!steady_run && $urandom_range(99) < 24) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Directed opening: empty table, read and write conflicts, duplicate ids,
	// adds to a full table and a remove while full.
	task automatic run_directed();
		offer_item(OP_PROBE, 16'hFFFF, 1'b1, 1'b1);
		offer_item(OP_REMOVE, 16'h0000, 1'b0, 1'b0);
		offer_item(OP_ADD_WRITE, 16'hFFFF, 1'b1, 1'b1);
		offer_item(OP_ADD_READ, 16'h0000, 1'b0, 1'b0);
		offer_item(OP_PROBE, 16'h0000, 1'b0, 1'b1);
		offer_item(OP_PROBE, 16'h0000, 1'b1, 1'b0);
		offer_item(OP_ADD_WRITE, 16'h0000, 1'b0, 1'b0);
		offer_item(OP_REMOVE, 16'h0000, 1'b1, 1'b1);
		offer_item(OP_PROBE, 16'h0000, 1'b0, 1'b1);
		for (int k = 0; k < MAX_LOCKS - 2; k++)
			offer_item((k % 2) ? OP_ADD_WRITE : OP_ADD_READ, 16'h0001 << k, 1'b0, 1'b0);
		offer_item(OP_ADD_WRITE, 16'h7FFF, 1'b0, 1'b0);
		offer_item(OP_ADD_READ, 16'h8000, 1'b0, 1'b0);
		offer_item(OP_REMOVE, 16'hFFFF, 1'b0, 1'b0);
	endtask

	// Random sequences that swing the table between filling and draining.
	// Most ids come from a small pool so that removes and probes hit.
	task automatic run_random();
		logic [LOCK_ID_W-1:0] hot_ids[6];
		logic [OP_W-1:0]      op;
		logic [LOCK_ID_W-1:0] id;
		bit                   filling;
		int                   r;
		filling = 1;
		foreach (hot_ids[j])
			hot_ids[j] = LOCK_ID_W'($urandom);
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 40 == 39) begin
				filling = !filling;
				hot_ids[$urandom_range(5)] = LOCK_ID_W'($urandom);
			end
			steady_run = (k >= 400 && k < 560);
			r = $urandom_range(99);
			if (filling)
				op = (r < 35) ? OP_ADD_WRITE : (r < 60) ? OP_ADD_READ :
					(r < 75) ? OP_REMOVE : OP_PROBE;
			else
				op = (r < 10) ? OP_ADD_WRITE : (r < 20) ? OP_ADD_READ :
					(r < 60) ? OP_REMOVE : OP_PROBE;
			id = ($urandom_range(99) < 80) ? hot_ids[$urandom_range(5)] : LOCK_ID_W'($urandom);
			offer_item(op, id, 1'($urandom_range(1)), $urandom_range(99) < 25);
		end
		steady_run = 0;
	endtask

	// Result side: random pops, one long hold-off, and no idling in the steady run.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (!hold_done && sb.results_seen >= 150) begin
				pop <= 1'b0;
				hold_left = HOLD_CYCLES - 1;
				hold_done = 1;
			end else if (steady_run) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= 24);
			end
		end
	end

	// Watchdog: ends the run when nothing transfers for too long.
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb_lockset_table_exclusion_unit: errors");
		$finish;
	end

	// Reset, stimulus, drain and verdict.
	initial begin
		sb = new();
		steady_run = 0;
		arst_n <= 1'b0;
		push <= 1'b0;
		operation <= OP_ADD_WRITE;
		lock_id <= '0;
		probe_is_write <= 1'b0;
		query_start <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		push <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_lockset_table_exclusion_unit: clean");
		else
			$display("tb_lockset_table_exclusion_unit: errors");
		$finish;
	end

endmodule
